>>> hw/rtl/ism_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants of the integer stack machine: operation and
// status codes, cell commands and the control bundle for the cell chain.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned DEPTH_OUT_W   = 8;
  localparam int unsigned DEFAULT_DEPTH = 128;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_DUP  = 3'd2,
    OP_DUMP = 3'd3,
    OP_SHR  = 3'd4,
    OP_SHL  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,   // from the neighbor nearer the top (push direction)
    CELL_NEXT = 2'd2    // from the neighbor farther from the top (pop direction)
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e         top_cmd;
    cell_cmd_e         rest_cmd;
    logic [DATA_W-1:0] top_value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ism_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ism_cell
// One stack entry. Holds its word, or loads the word of the neighbor above
// or below it, as commanded.
// ----------------------------------------------------------------------------
module ism_cell (
  input  wire logic                      clk_i,
  input  wire ism_pkg::cell_cmd_e        cmd_i,
  input  wire logic [ism_pkg::DATA_W-1:0] prev_i,
  input  wire logic [ism_pkg::DATA_W-1:0] next_i,
  output logic      [ism_pkg::DATA_W-1:0] value_o
);

  logic [ism_pkg::DATA_W-1:0] value_d, value_q;

  always_comb begin
    case (cmd_i)
      ism_pkg::CELL_PREV: value_d = prev_i;
      ism_pkg::CELL_NEXT: value_d = next_i;
      default:            value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> hw/rtl/ism_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ism_ctrl
// Instruction decode, depth counter, top-of-stack arithmetic and result
// registers. Drives the shift commands of the cell chain.
// ----------------------------------------------------------------------------
module ism_ctrl #(
  parameter int unsigned StackDepth = ism_pkg::DEFAULT_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [ism_pkg::OP_W-1:0]       operation_i,
  input  wire logic [ism_pkg::DATA_W-1:0]     push_value_i,
  input  wire logic [ism_pkg::DATA_W-1:0]     top_i,
  input  wire logic [ism_pkg::DATA_W-1:0]     second_i,
  output ism_pkg::cell_ctrl_t                 cell_ctrl_o,
  output logic                                done_o,
  output logic                                dump_valid_o,
  output logic      [ism_pkg::DATA_W-1:0]     dump_value_o,
  output logic      [ism_pkg::STATUS_W-1:0]   status_o,
  output logic      [ism_pkg::DEPTH_OUT_W-1:0] stack_depth_o
);

  localparam int unsigned DepthW = $clog2(StackDepth + 1);

  logic [DepthW-1:0]          cnt_d, cnt_q;
  logic                       done_q;
  logic                       dump_valid_d, dump_valid_q;
  logic [ism_pkg::DATA_W-1:0] dump_value_d, dump_value_q;
  ism_pkg::status_e           status_d, status_q;
  ism_pkg::cell_ctrl_t        cell_ctrl;
  logic                       empty, full, below_two;
  logic [DepthW+ism_pkg::DEPTH_OUT_W-1:0] cnt_ext;

  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == DepthW'(StackDepth));
  assign below_two = (cnt_q < DepthW'(2));

  always_comb begin
    cnt_d                 = cnt_q;
    status_d              = ism_pkg::ST_OK;
    dump_valid_d          = 1'b0;
    dump_value_d          = '0;
    cell_ctrl.top_cmd     = ism_pkg::CELL_HOLD;
    cell_ctrl.rest_cmd    = ism_pkg::CELL_HOLD;
    cell_ctrl.top_value   = push_value_i;
    if (start_i) begin
      case (ism_pkg::op_e'(operation_i))
        ism_pkg::OP_PUSH: begin
          if (full) begin
            status_d = ism_pkg::ST_OVER;
          end else begin
            cell_ctrl.top_cmd  = ism_pkg::CELL_PREV;
            cell_ctrl.rest_cmd = ism_pkg::CELL_PREV;
            cnt_d              = cnt_q + DepthW'(1);
          end
        end
        ism_pkg::OP_ADD: begin
          if (below_two) begin
            status_d = ism_pkg::ST_UNDER;
          end else begin
            cell_ctrl.top_cmd   = ism_pkg::CELL_PREV;
            cell_ctrl.rest_cmd  = ism_pkg::CELL_NEXT;
            cell_ctrl.top_value = top_i + second_i;
            cnt_d               = cnt_q - DepthW'(1);
          end
        end
        ism_pkg::OP_DUP: begin
          if (empty) begin
            status_d = ism_pkg::ST_UNDER;
          end else if (full) begin
            status_d = ism_pkg::ST_OVER;
          end else begin
            // cell 1 picks up the old top from cell 0, cell 0 reloads it
            cell_ctrl.top_cmd   = ism_pkg::CELL_PREV;
            cell_ctrl.rest_cmd  = ism_pkg::CELL_PREV;
            cell_ctrl.top_value = top_i;
            cnt_d               = cnt_q + DepthW'(1);
          end
        end
        ism_pkg::OP_DUMP: begin
          if (empty) begin
            status_d = ism_pkg::ST_UNDER;
          end else begin
            cell_ctrl.top_cmd  = ism_pkg::CELL_NEXT;
            cell_ctrl.rest_cmd = ism_pkg::CELL_NEXT;
            dump_valid_d       = 1'b1;
            dump_value_d       = top_i;
            cnt_d              = cnt_q - DepthW'(1);
          end
        end
        ism_pkg::OP_SHR: begin
          if (empty) begin
            status_d = ism_pkg::ST_UNDER;
          end else begin
            cell_ctrl.top_cmd   = ism_pkg::CELL_PREV;
            cell_ctrl.top_value = {top_i[ism_pkg::DATA_W-1], top_i[ism_pkg::DATA_W-1:1]};
          end
        end
        ism_pkg::OP_SHL: begin
          if (empty) begin
            status_d = ism_pkg::ST_UNDER;
          end else begin
            cell_ctrl.top_cmd   = ism_pkg::CELL_PREV;
            cell_ctrl.top_value = {top_i[ism_pkg::DATA_W-2:0], 1'b0};
          end
        end
        default: begin
          // unused codes: no-op, status ok
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      done_q       <= 1'b0;
      dump_valid_q <= 1'b0;
      status_q     <= ism_pkg::ST_OK;
    end else begin
      cnt_q        <= cnt_d;
      done_q       <= start_i;
      dump_valid_q <= dump_valid_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dump_value_q <= dump_value_d;
  end

  assign cnt_ext       = {{ism_pkg::DEPTH_OUT_W{1'b0}}, cnt_q};
  assign cell_ctrl_o   = cell_ctrl;
  assign done_o        = done_q;
  assign dump_valid_o  = dump_valid_q;
  assign dump_value_o  = dump_value_q;
  assign status_o      = status_q;
  assign stack_depth_o = cnt_ext[ism_pkg::DEPTH_OUT_W-1:0];

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthW'(StackDepth))
    else $error("stack depth above capacity");

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_q)
    else $error("accepted word gave no result");

  a_error_keeps_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && status_d != ism_pkg::ST_OK |=> $stable(cnt_q))
    else $error("faulting instruction changed depth");

  a_idle_keeps_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> $stable(cnt_q))
    else $error("depth changed without an instruction");

  a_dump_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_valid_q |-> done_q && status_q == ism_pkg::ST_OK)
    else $error("dump word flagged without a good result");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/integer_stack_machine_unit.sv
`default_nettype none
// done_o strobes in the cycle after start_i, one result per instruction.
// Throughput: one instruction per cycle; busy_o stays low.
// Every stack entry is a cell in a shift chain, so push and pop touch only
// neighbors and the top two cells feed the add/shift logic directly.
// Reset clears the depth counter and result strobes; entry contents are
// undefined until pushed. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// integer_stack_machine_unit
// 64-bit integer stack machine: push, add, duplicate, dump and shifts on an
// operand stack built as a chain of shift cells.
// ----------------------------------------------------------------------------
module integer_stack_machine_unit #(
  parameter int unsigned StackDepth = ism_pkg::DEFAULT_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [ism_pkg::OP_W-1:0]        operation_i,
  input  wire logic [ism_pkg::DATA_W-1:0]      push_value_i,
  output logic                                 done_o,
  output logic                                 dump_valid_o,
  output logic      [ism_pkg::DATA_W-1:0]      dump_value_o,
  output logic      [ism_pkg::STATUS_W-1:0]    status_o,
  output logic      [ism_pkg::DEPTH_OUT_W-1:0] stack_depth_o
);

  logic [ism_pkg::DATA_W-1:0] entry [StackDepth];
  ism_pkg::cell_ctrl_t        cell_ctrl;
  logic                       accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  ism_ctrl #(
    .StackDepth(StackDepth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .top_i        (entry[0]),
    .second_i     (entry[1]),
    .cell_ctrl_o  (cell_ctrl),
    .done_o       (done_o),
    .dump_valid_o (dump_valid_o),
    .dump_value_o (dump_value_o),
    .status_o     (status_o),
    .stack_depth_o(stack_depth_o)
  );

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic [ism_pkg::DATA_W-1:0] prev_w, next_w;
    ism_pkg::cell_cmd_e         cmd_w;

    if (i == 0) begin : g_top
      assign prev_w = cell_ctrl.top_value;
      assign cmd_w  = cell_ctrl.top_cmd;
    end else begin : g_body
      assign prev_w = entry[i-1];
      assign cmd_w  = cell_ctrl.rest_cmd;
    end

    // bottom cell refills from itself; that slot is past the depth anyway
    if (i == StackDepth - 1) begin : g_bottom
      assign next_w = entry[i];
    end else begin : g_inner
      assign next_w = entry[i+1];
    end

    ism_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_w),
      .prev_i (prev_w),
      .next_i (next_w),
      .value_o(entry[i])
    );
  end

`ifndef ASSERT_OFF
  a_strobe_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without an accepted word");

  a_dump_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !dump_valid_o |-> dump_value_o == '0)
    else $error("dump value not zero on a non-dump result");

  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == ism_pkg::OP_PUSH && cell_ctrl.top_cmd == ism_pkg::CELL_PREV
    |=> entry[0] == $past(push_value_i))
    else $error("pushed word not on top");
`endif

endmodule

`default_nettype wire
